@@ hw/rtl/pdgss_pkg.sv @@
// Shared types, codes and constants of the pump guard and soft-start driver.
package pdgss_pkg;

   localparam int RAMP_STEPS_DEF     = 30;
   localparam int GUARD_PRESCALE_DEF = 10;

   localparam int LIMIT_W   = 16;
   localparam int TIME_W    = 16;
   localparam int ELAPSED_W = 17;
   localparam int PRESC_W   = 4;
   localparam int DUTY_W    = 10;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic [ELAPSED_W-1:0] PHASE_MARGIN = ELAPSED_W'(10);
   localparam logic [DUTY_W-1:0]    FULL_DUTY    = DUTY_W'(1000);

   localparam logic [LIMIT_W-1:0] WORK_LIMIT_RST  = LIMIT_W'(3600);
   localparam logic [LIMIT_W-1:0] PAUSE_LIMIT_RST = LIMIT_W'(3600);
   localparam logic [DUTY_W-1:0]  MIN_DUTY_RST    = DUTY_W'(250);

   typedef enum logic [1:0] {
      REG_WORK_LIMIT  = 2'd0,
      REG_PAUSE_LIMIT = 2'd1,
      REG_MIN_DUTY    = 2'd2,
      REG_DIRECT      = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_RAMP = 2'd1,
      MODE_FULL = 2'd2
   } drive_mode_type;

   typedef struct packed {
      logic                pump_request;
      logic [TIME_W-1:0]   work_time;
      logic [TIME_W-1:0]   pause_time;
      logic                clock_fault;
      logic                guard_tick;
      logic                drive_tick;
      logic                count_restart;
   } item_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] work_overtime_limit;
      logic [LIMIT_W-1:0] pause_overtime_limit;
      logic [DUTY_W-1:0]  ramp_min_duty;
      logic               direct_drive;
   } cfg_type;

endpackage

@@ hw/rtl/pdgss_guard.sv @@
// Phase watchdog: prescaler, elapsed count and held fault flag.
module pdgss_guard #(
   parameter int GUARD_PRESCALE = pdgss_pkg::GUARD_PRESCALE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  pdgss_pkg::item_type item,
   input  pdgss_pkg::cfg_type  cfg,
   output logic                fault_now
);

   logic                                last_request_ff, last_request_in;
   logic [pdgss_pkg::PRESC_W-1:0]       prescale_ff, prescale_in;
   logic [pdgss_pkg::ELAPSED_W-1:0]     elapsed_ff, elapsed_in;
   logic                                fault_ff, fault_in;

   logic [pdgss_pkg::PRESC_W-1:0]       presc_base, presc_inc;
   logic [pdgss_pkg::ELAPSED_W-1:0]     elapsed_base, elapsed_cnt, hard, phase_cap;
   logic                                fault_base;
   logic [pdgss_pkg::TIME_W-1:0]        phase_time;

   always_comb begin
      presc_base   = item.count_restart ? '0 : prescale_ff;
      elapsed_base = item.count_restart ? '0 : elapsed_ff;
      fault_base   = item.count_restart ? 1'b0 : fault_ff;

      presc_inc  = presc_base + pdgss_pkg::PRESC_W'(1);
      phase_time = item.pump_request ? item.work_time : item.pause_time;
      hard = pdgss_pkg::ELAPSED_W'(item.pump_request ? cfg.work_overtime_limit
                                                     : cfg.pause_overtime_limit);
      phase_cap = pdgss_pkg::ELAPSED_W'(phase_time) + pdgss_pkg::PHASE_MARGIN;

      last_request_in = last_request_ff;
      prescale_in     = presc_base;
      elapsed_in      = elapsed_base;
      fault_in        = fault_base;
      elapsed_cnt     = elapsed_base;

      if (item.guard_tick) begin
         if (item.pump_request != last_request_ff) begin
            last_request_in = item.pump_request;
            prescale_in     = '0;
            elapsed_in      = '0;
            fault_in        = 1'b0;
         end else begin
            if (presc_inc >= pdgss_pkg::PRESC_W'(GUARD_PRESCALE)) begin
               prescale_in = '0;
               elapsed_cnt = elapsed_base + pdgss_pkg::ELAPSED_W'(1);
            end else begin
               prescale_in = presc_inc;
            end
            priority if (elapsed_cnt >= hard) begin
               elapsed_in = hard + pdgss_pkg::ELAPSED_W'(1);
               fault_in   = 1'b1;
            end else if (elapsed_cnt >= phase_cap) begin
               elapsed_in = phase_cap + pdgss_pkg::ELAPSED_W'(1);
               fault_in   = 1'b1;
            end else begin
               elapsed_in = elapsed_cnt;
            end
         end
      end
   end

   assign fault_now = fault_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_request_ff <= 1'b0;
         prescale_ff     <= '0;
         elapsed_ff      <= '0;
         fault_ff        <= 1'b0;
      end else if (advance) begin
         last_request_ff <= last_request_in;
         prescale_ff     <= prescale_in;
         elapsed_ff      <= elapsed_in;
         fault_ff        <= fault_in;
      end
   end

endmodule

@@ hw/rtl/pdgss_drive.sv @@
// Drive step: enable tracking, soft-start ramp and full-on selection.
module pdgss_drive #(
   parameter int RAMP_STEPS = pdgss_pkg::RAMP_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  pdgss_pkg::item_type                item,
   input  logic                               fault_now,
   input  pdgss_pkg::cfg_type                 cfg,
   input  pdgss_pkg::cfg_type                 cfg_next,
   output pdgss_pkg::drive_mode_type          mode_now,
   output logic [pdgss_pkg::DUTY_W-1:0]       duty_now
);

   localparam int STEP_W  = $clog2(RAMP_STEPS + 1);
   localparam int PROD_W  = pdgss_pkg::DUTY_W + STEP_W;
   localparam int SHIFT   = PROD_W + $clog2(RAMP_STEPS);
   localparam int RECIP_W = SHIFT + 1;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS);

   logic                               enable_last_ff, enable_last_in;
   logic [STEP_W-1:0]                  step_ff, step_in;
   pdgss_pkg::drive_mode_type          mode_ff, mode_in;
   logic [pdgss_pkg::DUTY_W-1:0]       duty_ff, duty_in;
   logic [PROD_W-1:0]                  prod_ff, prod_in;

   logic                               enable;
   logic [STEP_W-1:0]                  step_cur, step_ahead;
   logic [pdgss_pkg::DUTY_W-1:0]       lo, lo_next, span_next;
   logic [PROD_W+RECIP_W-1:0]          scaled;
   logic [pdgss_pkg::DUTY_W-1:0]       quot;
   logic [pdgss_pkg::DUTY_W:0]         ramp_duty;

   always_comb begin
      enable   = item.pump_request & ~fault_now & ~item.clock_fault;
      step_cur = enable_last_ff ? step_ff : '0;
      lo = (cfg.ramp_min_duty > pdgss_pkg::FULL_DUTY) ? pdgss_pkg::FULL_DUTY
                                                      : cfg.ramp_min_duty;
      scaled    = PROD_W'(prod_ff) * RECIP_W'(RECIP);
      quot      = scaled[SHIFT +: pdgss_pkg::DUTY_W];
      ramp_duty = {1'b0, lo} + {1'b0, quot};

      enable_last_in = enable_last_ff;
      step_in        = step_ff;
      mode_in        = mode_ff;
      duty_in        = duty_ff;

      if (advance && item.drive_tick) begin
         enable_last_in = enable;
         if (!enable) begin
            mode_in = pdgss_pkg::MODE_OFF;
            duty_in = '0;
            step_in = '0;
         end else if (cfg.direct_drive || step_cur >= STEP_W'(RAMP_STEPS)) begin
            mode_in = pdgss_pkg::MODE_FULL;
            duty_in = pdgss_pkg::FULL_DUTY;
            step_in = step_cur;
         end else begin
            mode_in = pdgss_pkg::MODE_RAMP;
            duty_in = ramp_duty[pdgss_pkg::DUTY_W-1:0];
            step_in = step_cur + STEP_W'(1);
         end
      end

      lo_next = (cfg_next.ramp_min_duty > pdgss_pkg::FULL_DUTY) ? pdgss_pkg::FULL_DUTY
                                                                : cfg_next.ramp_min_duty;
      span_next  = pdgss_pkg::FULL_DUTY - lo_next;
      step_ahead = enable_last_in ? step_in : '0;
      prod_in    = PROD_W'(span_next) * PROD_W'(step_ahead);
   end

   assign mode_now = mode_in;
   assign duty_now = duty_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_last_ff <= 1'b0;
         step_ff        <= '0;
         mode_ff        <= pdgss_pkg::MODE_OFF;
         duty_ff        <= '0;
         prod_ff        <= '0;
      end else begin
         enable_last_ff <= enable_last_in;
         step_ff        <= step_in;
         mode_ff        <= mode_in;
         duty_ff        <= duty_in;
         prod_ff        <= prod_in;
      end
   end

endmodule

@@ hw/rtl/pump_drive_guard_soft_start_core.sv @@
// Top level of the pump guard and soft-start driver with stream and register ports.
//
//   Port group  Direction  Handshake          Content
//   req_*       in         tvalid/tready      one request per guard/drive event
//   rsp_*       out        tvalid/tready      fault, drive mode and duty
//   csr_*       in/out     psel/penable       limits, ramp start duty, direct mode
//
// A request is registered on entry and its result is registered in the response register,
// so one request is taken every cycle while the result is not stalled.
// The guard and drive state update in the result cycle, which closes the loop
// between consecutive requests. A stalled result holds both stages; reset clears
// all control state and loads the register defaults.
module pump_drive_guard_soft_start_core #(
   parameter int RAMP_STEPS     = pdgss_pkg::RAMP_STEPS_DEF,
   parameter int GUARD_PRESCALE = pdgss_pkg::GUARD_PRESCALE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] pump_request, [16:1] work_time, [32:17] pause_time, [33] clock_fault,
   // [34] guard_tick, [35] drive_tick, [36] count_restart, [39:37] zero
   input  logic [pdgss_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] pump_fault, [2:1] drive_mode, [12:3] pwm_duty, [15:13] zero
   output logic [pdgss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pdgss_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pdgss_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pdgss_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   pdgss_pkg::cfg_type               cfg_ff, cfg_in;
   pdgss_pkg::csr_reg_type           reg_sel;
   logic                             csr_write;

   logic                             in_valid_ff, in_valid_in;
   pdgss_pkg::item_type              in_item_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [pdgss_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic                             advance;
   logic                             fault_now;
   pdgss_pkg::drive_mode_type        mode_now;
   logic [pdgss_pkg::DUTY_W-1:0]     duty_now;

   assign csr_pready = 1'b1;
   assign reg_sel    = pdgss_pkg::csr_reg_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            pdgss_pkg::REG_WORK_LIMIT:
               cfg_in.work_overtime_limit = csr_pwdata[pdgss_pkg::LIMIT_W-1:0];
            pdgss_pkg::REG_PAUSE_LIMIT:
               cfg_in.pause_overtime_limit = csr_pwdata[pdgss_pkg::LIMIT_W-1:0];
            pdgss_pkg::REG_MIN_DUTY:
               cfg_in.ramp_min_duty = csr_pwdata[pdgss_pkg::DUTY_W-1:0];
            pdgss_pkg::REG_DIRECT:
               cfg_in.direct_drive = csr_pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         pdgss_pkg::REG_WORK_LIMIT:
            csr_prdata = pdgss_pkg::CSR_DATA_W'(cfg_ff.work_overtime_limit);
         pdgss_pkg::REG_PAUSE_LIMIT:
            csr_prdata = pdgss_pkg::CSR_DATA_W'(cfg_ff.pause_overtime_limit);
         pdgss_pkg::REG_MIN_DUTY:
            csr_prdata = pdgss_pkg::CSR_DATA_W'(cfg_ff.ramp_min_duty);
         pdgss_pkg::REG_DIRECT:
            csr_prdata = pdgss_pkg::CSR_DATA_W'(cfg_ff.direct_drive);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.work_overtime_limit  <= pdgss_pkg::WORK_LIMIT_RST;
         cfg_ff.pause_overtime_limit <= pdgss_pkg::PAUSE_LIMIT_RST;
         cfg_ff.ramp_min_duty        <= pdgss_pkg::MIN_DUTY_RST;
         cfg_ff.direct_drive         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.pump_request  <= req_tdata[0];
         in_item_ff.work_time     <= req_tdata[16:1];
         in_item_ff.pause_time    <= req_tdata[32:17];
         in_item_ff.clock_fault   <= req_tdata[33];
         in_item_ff.guard_tick    <= req_tdata[34];
         in_item_ff.drive_tick    <= req_tdata[35];
         in_item_ff.count_restart <= req_tdata[36];
      end
      if (advance) begin
         rsp_data_ff <= {3'b000, duty_now, mode_now, fault_now};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pdgss_guard #(
      .GUARD_PRESCALE (GUARD_PRESCALE)
   ) u_guard (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (in_item_ff),
      .cfg       (cfg_ff),
      .fault_now (fault_now)
   );

   pdgss_drive #(
      .RAMP_STEPS (RAMP_STEPS)
   ) u_drive (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (in_item_ff),
      .fault_now (fault_now),
      .cfg       (cfg_ff),
      .cfg_next  (cfg_in),
      .mode_now  (mode_now),
      .duty_now  (duty_now)
   );

endmodule

@@ hw/rtl/pdgss_checker.sv @@
// Port-level checks of the pump guard and soft-start driver, bound to the top level.
module pdgss_props (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pdgss_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   a_full_duty : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:1] == pdgss_pkg::MODE_FULL
      |-> rsp_tdata[12:3] == pdgss_pkg::FULL_DUTY)
      else $error("full-on result without full duty");

   a_off_duty : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:1] == pdgss_pkg::MODE_OFF
      |-> rsp_tdata[12:3] == '0)
      else $error("off result with nonzero duty");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind pump_drive_guard_soft_start_core pdgss_props u_pdgss_props (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
